/* hw/rtl/polar_to_cartesian_degrees_defines.svh */
// Assertion macros shared by the polar to cartesian converter.
`ifndef POLAR_TO_CARTESIAN_DEGREES_DEFINES_SVH
`define POLAR_TO_CARTESIAN_DEGREES_DEFINES_SVH
`ifndef SYNTHESIS
`define P2C_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
	else $error("p2c: implication violated");
`define P2C_NEVER(lbl, ck, rn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
	else $error("p2c: forbidden condition seen");
`else
`define P2C_ASSERT(lbl, ck, rn, prop)
`define P2C_NEVER(lbl, ck, rn, expr)
`endif
`endif

/* hw/rtl/p2c_pkg.sv */
// Types, constants and the arctangent table of the polar to cartesian converter.
package p2c_pkg;

	localparam int RADIUS_W = 16;
	localparam int ANGLE_W  = 18;
	localparam int COORD_W  = 16;

	// Working widths: x/y in Q22 with CORDIC growth, z in 2^-24 degree
	localparam int XW      = 32;
	localparam int ZW      = 34;
	localparam int PROD_W  = RADIUS_W + 31;

	localparam int TABLE_LEN       = 24;
	localparam int ROT_STAGES_DEF  = 16;

	localparam logic [29:0] GAIN_Q30 = 30'd652032874;
	localparam int GAIN_SHIFT   = 16;
	localparam int GAIN_ROUND   = 32768;

	localparam int TURN_UNITS   = 46080;
	localparam int HALF_TURN    = 23040;
	localparam int QUARTER_TURN = 11520;
	localparam int ANGLE_BIAS   = 3 * TURN_UNITS;
	localparam int BIAS_W       = 19;
	localparam int MOD_W        = 16;
	localparam int FOLD_W       = 15;
	localparam int Z_SHIFT      = 17;

	localparam int OUT_SHIFT    = 14;
	localparam int OUT_ROUND    = 8192;
	localparam int COORD_MAX    = 32767;
	localparam int COORD_MIN    = -32768;

	localparam logic [29:0] ATAN_Q24 [TABLE_LEN] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
		30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
		30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
		30'd234684,    30'd117342,    30'd58671,     30'd29335,
		30'd14668,     30'd7334,      30'd3667,      30'd1833,
		30'd917,       30'd458,       30'd229,       30'd115
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_t;

endpackage

/* hw/rtl/p2c_polar_if.sv */
// Input channel: radius and angle beat with valid/ready.
interface p2c_polar_if
	import p2c_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [RADIUS_W-1:0] radius;
	logic signed [ANGLE_W-1:0]  angle_deg;

	modport source (output valid, radius, angle_deg, input ready);
	modport sink (input valid, radius, angle_deg, output ready);
endinterface

/* hw/rtl/p2c_rect_if.sv */
// Output channel: x/y coordinate beat with valid/ready.
interface p2c_rect_if
	import p2c_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;

	modport source (output valid, x_coord, y_coord, input ready);
	modport sink (input valid, x_coord, y_coord, output ready);
endinterface

/* hw/rtl/p2c_prep.sv */
// Gain compensation and angle reduction ahead of the rotation chain.
`include "polar_to_cartesian_degrees_defines.svh"
module p2c_prep
	import p2c_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	p2c_polar_if.sink      polar,
	output logic           dn_valid,
	input  logic           dn_ready,
	output rot_t           dn
);

	logic                     valid_s1;
	logic                     valid_s2;
	logic                     ready_s1;
	logic                     ready_s2;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [FOLD_W-1:0] m_s1;
	logic                     neg_s1;
	rot_t                     rot_s2;

	logic signed [19:0]       a_bias;
	logic [BIAS_W-1:0]        u;
	logic [BIAS_W-1:0]        sub;
	logic [MOD_W-1:0]         m0;
	logic signed [16:0]       ms;
	logic signed [FOLD_W-1:0] mf;
	logic                     neg;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [XW-1:0]     v0;

	assign ready_s2    = !valid_s2 || dn_ready;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign polar.ready = ready_s1;

	// Reduce the angle modulo one turn: bias positive, then take off whole turns
	always_comb begin
		a_bias = 20'(polar.angle_deg) + 20'(ANGLE_BIAS);
		u      = a_bias[BIAS_W-1:0];
		sub    = '0;
		for (int j = 1; j <= 5; j++) begin
			if (u >= BIAS_W'(j * TURN_UNITS)) begin
				sub = BIAS_W'(j * TURN_UNITS);
			end
		end
		m0 = MOD_W'(u - sub);
		if (m0 >= MOD_W'(HALF_TURN)) begin
			ms = $signed({1'b0, m0}) - 17'(TURN_UNITS);
		end else begin
			ms = $signed({1'b0, m0});
		end
		// Fold into [-90, +90] degrees, flipping the vector
		neg = 1'b0;
		mf  = FOLD_W'(ms);
		if (ms > 17'(QUARTER_TURN)) begin
			neg = 1'b1;
			mf  = FOLD_W'(ms - 17'(HALF_TURN));
		end else if (ms < -17'(QUARTER_TURN)) begin
			neg = 1'b1;
			mf  = FOLD_W'(ms + 17'(HALF_TURN));
		end
	end

	assign prod = PROD_W'(polar.radius) * PROD_W'($signed({1'b0, GAIN_Q30}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= polar.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (polar.valid && ready_s1) begin
			prod_s1 <= prod;
			m_s1    <= mf;
			neg_s1  <= neg;
		end
	end

	always_comb begin
		prod_rnd = prod_s1 + PROD_W'(GAIN_ROUND);
		v0       = XW'(prod_rnd >>> GAIN_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			rot_s2.x <= neg_s1 ? -v0 : v0;
			rot_s2.y <= '0;
			rot_s2.z <= ZW'(m_s1) <<< Z_SHIFT;
		end
	end

	assign dn_valid = valid_s2;
	assign dn       = rot_s2;

	`P2C_ASSERT(a_accept_fills_s1, clk, arst_n, polar.valid && polar.ready |=> valid_s1)
	`P2C_ASSERT(a_fold_range, clk, arst_n, valid_s1 |-> m_s1 <= QUARTER_TURN && m_s1 >= -QUARTER_TURN)

endmodule

/* hw/rtl/p2c_cell.sv */
// One CORDIC rotation cell: a micro-rotation by atan(2^-STAGE) and its register.
module p2c_cell
	import p2c_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  rot_t up,
	output logic dn_valid,
	input  logic dn_ready,
	output rot_t dn
);

	localparam logic signed [ZW-1:0] ANGLE_STEP = ZW'(ATAN_Q24[STAGE]);

	logic                 valid_q;
	rot_t                 rot_q;
	rot_t                 rot_nxt;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	assign up_ready = !valid_q || dn_ready;

	// Rotate toward zero residual angle
	always_comb begin
		dx = up.y >>> STAGE;
		dy = up.x >>> STAGE;
		if (!up.z[ZW-1]) begin
			rot_nxt.x = up.x - dx;
			rot_nxt.y = up.y + dy;
			rot_nxt.z = up.z - ANGLE_STEP;
		end else begin
			rot_nxt.x = up.x + dx;
			rot_nxt.y = up.y - dy;
			rot_nxt.z = up.z + ANGLE_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			rot_q <= rot_nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn       = rot_q;

endmodule

/* hw/rtl/p2c_out.sv */
// Output stage: round Q22 to Q8, saturate to 16 bits and hold the result beat.
module p2c_out
	import p2c_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  rot_t      up,
	p2c_rect_if.source rect
);

	localparam logic signed [XW:0] SAT_HI = (XW+1)'(COORD_MAX);
	localparam logic signed [XW:0] SAT_LO = (XW+1)'(COORD_MIN);

	logic                      valid_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic signed [XW:0]        x_rnd;
	logic signed [XW:0]        y_rnd;
	logic signed [COORD_W-1:0] x_sat;
	logic signed [COORD_W-1:0] y_sat;

	assign up_ready = !valid_q || rect.ready;

	always_comb begin
		x_rnd = ((XW+1)'(up.x) + (XW+1)'(OUT_ROUND)) >>> OUT_SHIFT;
		y_rnd = ((XW+1)'(up.y) + (XW+1)'(OUT_ROUND)) >>> OUT_SHIFT;
		if (x_rnd > SAT_HI) begin
			x_sat = COORD_W'(COORD_MAX);
		end else if (x_rnd < SAT_LO) begin
			x_sat = COORD_W'(COORD_MIN);
		end else begin
			x_sat = COORD_W'(x_rnd);
		end
		if (y_rnd > SAT_HI) begin
			y_sat = COORD_W'(COORD_MAX);
		end else if (y_rnd < SAT_LO) begin
			y_sat = COORD_W'(COORD_MIN);
		end else begin
			y_sat = COORD_W'(y_rnd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			x_q <= x_sat;
			y_q <= y_sat;
		end
	end

	assign rect.valid   = valid_q;
	assign rect.x_coord = x_q;
	assign rect.y_coord = y_q;

endmodule

/* hw/rtl/polar_to_cartesian_degrees.sv */
// Polar (radius, angle in 1/128 degree) to cartesian converter, CORDIC chain.
// Takes one beat per clock unless the output stalls, returning x = r*cos(a),
// y = r*sin(a) in Q8, rounded and saturated to 16 bits, one result beat per
// input beat, in order. The result is registered after the gain multiply and
// angle reduction, after rounding the gain and flipping the vector, in each
// rotation cell and in the output register. Each cell does one shift-and-add
// micro-rotation per clock, so the chain sustains one item per cycle unless
// stalled; a stalled output fills the chain cell by cell before ready drops.
`include "polar_to_cartesian_degrees_defines.svh"
module polar_to_cartesian_degrees
	import p2c_pkg::*;
#(
	parameter int ROTATION_STAGES = ROT_STAGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	p2c_polar_if.sink  polar,
	p2c_rect_if.source rect
);

	logic valid_c [0:ROTATION_STAGES];
	logic ready_c [0:ROTATION_STAGES];
	rot_t rot_c   [0:ROTATION_STAGES];

	p2c_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.polar    (polar),
		.dn_valid (valid_c[0]),
		.dn_ready (ready_c[0]),
		.dn       (rot_c[0])
	);

	for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
		p2c_cell #(
			.STAGE (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[g]),
			.up_ready (ready_c[g]),
			.up       (rot_c[g]),
			.dn_valid (valid_c[g+1]),
			.dn_ready (ready_c[g+1]),
			.dn       (rot_c[g+1])
		);
	end

	p2c_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_c[ROTATION_STAGES]),
		.up_ready (ready_c[ROTATION_STAGES]),
		.up       (rot_c[ROTATION_STAGES]),
		.rect     (rect)
	);

	// Input may only back up when the whole chain is full behind a stalled output
	`P2C_ASSERT(a_ready_only_on_stall, clk, arst_n, !polar.ready |-> rect.valid && !rect.ready)

endmodule
